[rtl/mbist_pkg.sv]
// shared types, constants and register map of the memory self-test sequencer
package mbist_pkg;

	localparam int AddrBits = 32;
	localparam logic [63:0] AddrMaskWide = (64'd1 << AddrBits) - 64'd1;

	localparam logic [63:0] PatA = 64'hAAAA_AAAA_AAAA_AAAA;
	localparam logic [63:0] Pat5 = 64'h5555_5555_5555_5555;

	localparam int PaddrW = 4;
	localparam logic [5:0] MaxSizeLog2 = 6'd32;

	typedef enum logic [1:0] {
		REG_BASE = 2'd0,
		REG_SIZE = 2'd1,
		REG_FULL = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE         = 4'd0,
		ST_DB_WR        = 4'd1,
		ST_DB_RD        = 4'd2,
		ST_AB_FILL      = 4'd3,
		ST_AB_BASE_ANTI = 4'd4,
		ST_AB_CHECK     = 4'd5,
		ST_AB_BASE_PAT  = 4'd6,
		ST_AB_PROBE_WR  = 4'd7,
		ST_AB_BASE_RD   = 4'd8,
		ST_AB_SCAN      = 4'd9,
		ST_AB_RESTORE   = 4'd10,
		ST_DV_FILL      = 4'd11,
		ST_DV_CHECK1    = 4'd12,
		ST_DV_INVERT    = 4'd13,
		ST_DV_CHECK2    = 4'd14
	} step_t;

	typedef enum logic [2:0] {
		CMD_IDLE  = 3'd0,
		CMD_WRITE = 3'd1,
		CMD_READ  = 3'd2,
		CMD_PASS  = 3'd3,
		CMD_FAIL  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		PH_NONE      = 3'd0,
		PH_DATA_BUS  = 3'd1,
		PH_ADDR_STUCK = 3'd2,
		PH_BASE_DIST = 3'd3,
		PH_ALIAS     = 3'd4,
		PH_PASS1     = 3'd5,
		PH_PASS2     = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		K_IDLE   = 2'd0,
		K_ISSUE  = 2'd1,
		K_FINISH = 2'd2
	} kind_t;

	typedef struct packed {
		logic [31:0] base_word_address;
		logic [5:0]  size_log2;
		logic        full_test;
	} cfg_t;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] address;
		logic [63:0] write_data;
		phase_t      fail_phase;
		logic [31:0] fail_offset;
		logic [63:0] fail_bits;
	} res_t;

endpackage

[rtl/memory_bist_sequencer.sv]
// top level of the memory self-test sequencer: request and result registers
//
// usage:
//   s_* carries requests: s_tuser is the kind (0 start or restart, 1 previous command
//   completed), s_tdata the read data of the previous command when it was a read.
//   m_* carries one result per request: m_tuser is the command (idle, write, read,
//   finished pass, finished fail), m_tdata the address, write data and failure report.
//   apb port at byte addresses 0, 4, 8: base word address, log2 of size, full test.
//   write the registers only while no request is in flight.
//   a request in the request register passes through the decision logic into the
//   result register, which drives m_*. throughput: one request per cycle while m_*
//   is not stalled, since the whole sequencer step is one pass through the decision
//   logic between the request register and the result register.
//   a stalled m_tready holds the result; one more request is taken into the
//   request register, then s_tready drops until the result moves on.
//   reset clears both registers, the test state (idle) and the configuration
//   (base 0, size 2^16 words, full test on).
module memory_bist_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [63:0]                   s_tdata,  // read_data
	input  logic [0:0]                    s_tuser,  // action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// address, write_data, fail_phase, fail_offset, fail_bits, zero fill
	output logic [199:0]                  m_tdata,
	output logic [2:0]                    m_tuser,  // command
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mbist_pkg::PaddrW-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import mbist_pkg::*;

	cfg_t        cfg;
	res_t        res;
	res_t        res_s2;
	logic        vld_s1, vld_s2;
	logic        act_s1;
	logic [63:0] rdata_s1;
	logic        adv, fire, take;

	assign adv      = !vld_s2 || m_tready;
	assign fire     = vld_s1 && adv;
	assign s_tready = !vld_s1 || adv;
	assign take     = s_tvalid && s_tready;

	mbist_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mbist_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.cfg       (cfg),
		.action    (act_s1),
		.read_data (rdata_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (take) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			act_s1   <= s_tuser[0];
			rdata_s1 <= s_tdata;
		end
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tuser  = res_s2.command;
	assign m_tdata  = {5'd0, res_s2.fail_bits, res_s2.fail_offset, res_s2.fail_phase,
		res_s2.write_data, res_s2.address};

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1)
		else $error("pending request dropped");

	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> vld_s2)
		else $error("processed request gave no result");

endmodule

[rtl/mbist_regs.sv]
// apb configuration registers of the memory self-test sequencer
module mbist_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mbist_pkg::PaddrW-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output mbist_pkg::cfg_t               cfg
);
	import mbist_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_word_address <= 32'd0;
			cfg_q.size_log2         <= 6'd16;
			cfg_q.full_test         <= 1'b1;
		end else if (wr_en) begin
			unique case (idx)
				REG_BASE: cfg_q.base_word_address <= pwdata;
				REG_SIZE: cfg_q.size_log2         <= pwdata[5:0];
				REG_FULL: cfg_q.full_test         <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BASE: prdata = cfg_q.base_word_address;
			REG_SIZE: prdata = {26'd0, cfg_q.size_log2};
			REG_FULL: prdata = {31'd0, cfg_q.full_test};
			default:  prdata = 32'd0;
		endcase
	end

endmodule

[rtl/mbist_seq.sv]
// test sequence state and the per-request command decision
module mbist_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  mbist_pkg::cfg_t cfg,
	input  logic            action,
	input  logic [63:0]     read_data,
	output mbist_pkg::res_t res
);
	import mbist_pkg::*;

	step_t       step_q, step_d, nstep;
	logic [31:0] walk_q, walk_d;
	logic [31:0] probe_q, probe_d;
	logic [5:0]  bit_q, bit_d;
	logic        lwr_q, lwr_d;

	kind_t       kind;
	logic        nread;
	logic [31:0] noff;
	logic [63:0] ndata;
	phase_t      nphase;
	logic [31:0] nfoff;
	logic [63:0] nfbits;

	logic [5:0]  size_eff;
	logic [31:0] m;
	logic [63:0] rd;
	logic [31:0] nw, np;
	logic        nw_hit, np_hit;
	logic [32:0] w1, w2;
	logic [63:0] pat;
	logic [32:0] addr_sum;

	assign size_eff = (cfg.size_log2 > MaxSizeLog2) ? MaxSizeLog2 : cfg.size_log2;
	assign m        = 32'((33'd1 << size_eff) - 33'd1);
	assign rd       = lwr_q ? read_data : 64'd0;
	assign nw       = {walk_q[30:0], 1'b0};
	assign np       = {probe_q[30:0], 1'b0};
	assign nw_hit   = |(nw & m);
	assign np_hit   = |(np & m);
	assign w1       = {1'b0, walk_q} + 33'd1;
	assign w2       = {1'b0, walk_q} + 33'd2;
	assign pat      = 64'd1 << bit_q;

	always_comb begin : next_state
		walk_d  = walk_q;
		probe_d = probe_q;
		bit_d   = bit_q;
		kind    = K_ISSUE;
		nstep   = ST_IDLE;
		nread   = 1'b0;
		noff    = 32'd0;
		ndata   = 64'd0;
		nphase  = PH_NONE;
		nfoff   = 32'd0;
		nfbits  = 64'd0;
		if (!action) begin
			walk_d  = 32'd0;
			probe_d = 32'd0;
			bit_d   = 6'd0;
			nstep   = ST_DB_WR;
			ndata   = 64'd1;
		end else begin
			unique case (step_q) inside
				ST_DB_WR: begin
					nstep = ST_DB_RD;
					nread = 1'b1;
				end
				ST_DB_RD: begin
					if (rd != pat) begin
						kind   = K_FINISH;
						nphase = PH_DATA_BUS;
						nfbits = pat;
					end else if (bit_q == 6'd63) begin
						if (m[0]) begin
							walk_d = 32'd1;
							nstep  = ST_AB_FILL;
							noff   = 32'd1;
							ndata  = PatA;
						end else begin
							nstep = ST_AB_BASE_ANTI;
							ndata = Pat5;
						end
					end else begin
						bit_d = bit_q + 6'd1;
						nstep = ST_DB_WR;
						ndata = 64'd1 << (bit_q + 6'd1);
					end
				end
				ST_AB_FILL: begin
					if (nw_hit) begin
						walk_d = nw;
						nstep  = ST_AB_FILL;
						noff   = nw;
						ndata  = PatA;
					end else begin
						nstep = ST_AB_BASE_ANTI;
						ndata = Pat5;
					end
				end
				ST_AB_BASE_ANTI: begin
					if (m[0]) begin
						walk_d = 32'd1;
						nstep  = ST_AB_CHECK;
						nread  = 1'b1;
						noff   = 32'd1;
					end else begin
						nstep = ST_AB_BASE_PAT;
						ndata = PatA;
					end
				end
				ST_AB_CHECK: begin
					if (rd != PatA) begin
						kind   = K_FINISH;
						nphase = PH_ADDR_STUCK;
						nfoff  = walk_q;
					end else if (nw_hit) begin
						walk_d = nw;
						nstep  = ST_AB_CHECK;
						nread  = 1'b1;
						noff   = nw;
					end else begin
						nstep = ST_AB_BASE_PAT;
						ndata = PatA;
					end
				end
				ST_AB_PROBE_WR: begin
					nstep = ST_AB_BASE_RD;
					nread = 1'b1;
				end
				ST_AB_BASE_RD: begin
					if (rd != PatA) begin
						kind   = K_FINISH;
						nphase = PH_BASE_DIST;
						nfoff  = probe_q;
					end else begin
						walk_d = 32'd1;
						nstep  = ST_AB_SCAN;
						nread  = 1'b1;
						noff   = 32'd1;
					end
				end
				ST_AB_SCAN: begin
					// the probe offset itself is read but not compared
					if (rd != PatA && walk_q != probe_q) begin
						kind   = K_FINISH;
						nphase = PH_ALIAS;
						nfoff  = probe_q;
					end else if (nw_hit) begin
						walk_d = nw;
						nstep  = ST_AB_SCAN;
						nread  = 1'b1;
						noff   = nw;
					end else begin
						nstep = ST_AB_RESTORE;
						noff  = probe_q;
						ndata = PatA;
					end
				end
				ST_AB_BASE_PAT, ST_AB_RESTORE: begin
					if (step_q == ST_AB_BASE_PAT && m[0]) begin
						probe_d = 32'd1;
						nstep   = ST_AB_PROBE_WR;
						noff    = 32'd1;
						ndata   = Pat5;
					end else if (step_q == ST_AB_RESTORE && np_hit) begin
						probe_d = np;
						nstep   = ST_AB_PROBE_WR;
						noff    = np;
						ndata   = Pat5;
					end else if (cfg.full_test) begin
						// start of the device test
						walk_d = 32'd0;
						nstep  = ST_DV_FILL;
						ndata  = 64'd1;
					end else begin
						kind = K_FINISH;
					end
				end
				ST_DV_FILL: begin
					if (walk_q >= m) begin
						walk_d = 32'd0;
						nstep  = ST_DV_CHECK1;
						nread  = 1'b1;
					end else begin
						walk_d = w1[31:0];
						nstep  = ST_DV_FILL;
						noff   = w1[31:0];
						ndata  = 64'(w2);
					end
				end
				ST_DV_CHECK1: begin
					if (rd != 64'(w1)) begin
						kind   = K_FINISH;
						nphase = PH_PASS1;
						nfoff  = walk_q;
					end else begin
						nstep = ST_DV_INVERT;
						noff  = walk_q;
						ndata = ~64'(w1);
					end
				end
				ST_DV_INVERT: begin
					nread = 1'b1;
					if (walk_q >= m) begin
						walk_d = 32'd0;
						nstep  = ST_DV_CHECK2;
					end else begin
						walk_d = w1[31:0];
						nstep  = ST_DV_CHECK1;
						noff   = w1[31:0];
					end
				end
				ST_DV_CHECK2: begin
					if (rd != ~64'(w1)) begin
						kind   = K_FINISH;
						nphase = PH_PASS2;
						nfoff  = walk_q;
					end else if (walk_q >= m) begin
						kind = K_FINISH;
					end else begin
						walk_d = w1[31:0];
						nstep  = ST_DV_CHECK2;
						nread  = 1'b1;
						noff   = w1[31:0];
					end
				end
				default: kind = K_IDLE;
			endcase
		end
		step_d = (kind == K_ISSUE) ? nstep : ST_IDLE;
		lwr_d  = (kind == K_ISSUE) && nread;
	end

	assign addr_sum = {1'b0, cfg.base_word_address} + {1'b0, noff};

	always_comb begin : outputs
		res = '0;
		case (kind)
			K_ISSUE: begin
				res.command    = nread ? CMD_READ : CMD_WRITE;
				res.address    = addr_sum[31:0] & AddrMaskWide[31:0];
				res.write_data = nread ? 64'd0 : ndata;
			end
			K_FINISH: begin
				res.command     = (nphase == PH_NONE) ? CMD_PASS : CMD_FAIL;
				res.fail_phase  = nphase;
				res.fail_offset = nfoff;
				res.fail_bits   = nfbits;
			end
			default: res.command = CMD_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_IDLE;
			walk_q  <= 32'd0;
			probe_q <= 32'd0;
			bit_q   <= 6'd0;
			lwr_q   <= 1'b0;
		end else if (fire) begin
			step_q  <= step_d;
			walk_q  <= walk_d;
			probe_q <= probe_d;
			bit_q   <= bit_d;
			lwr_q   <= lwr_d;
		end
	end

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && kind == K_FINISH |=> step_q == ST_IDLE && !lwr_q)
		else $error("sequencer not idle after a finish");

	a_read_states: assert property (@(posedge clk) disable iff (!arst_n)
		lwr_q |-> step_q == ST_DB_RD || step_q == ST_AB_CHECK || step_q == ST_AB_BASE_RD
			|| step_q == ST_AB_SCAN || step_q == ST_DV_CHECK1 || step_q == ST_DV_CHECK2)
		else $error("read flag set in a state that follows a write");

	a_start_write: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !action |=> step_q == ST_DB_WR && bit_q == 6'd0)
		else $error("start did not restart the data bus test");

endmodule

[tb/testbench.sv]
// self-checking testbench of the memory self-test sequencer, driven by an ideal memory image
`timescale 1ns / 100ps

module testbench;
	import mbist_pkg::*;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_DONE  = 1'b1;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [63:0]         s_tdata;   // read_data
	logic [0:0]          s_tuser;   // action
	logic                m_tvalid;
	logic                m_tready;
	// address, write_data, fail_phase, fail_offset, fail_bits, zero fill
	logic [199:0]        m_tdata;
	logic [2:0]          m_tuser;   // command
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PaddrW-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	memory_bist_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// sequencer model: configuration and test state
	logic [31:0] cfg_base;
	logic [5:0]  cfg_size;
	logic        cfg_full;
	step_t       seq_step;
	logic [31:0] walk_pos;
	logic [31:0] probe_pos;
	logic [5:0]  bit_pos;
	logic        last_read;
	res_t        issued;

	res_t        expected_cmds[$];
	logic [63:0] mem_image[logic [31:0]];

	int errors;
	int corrupt_odds;
	bit calm;
	int n_requests, n_runs, n_pass, n_fail;
	logic [6:0] phases_seen;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic void check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
		end
	endfunction

	function automatic logic [63:0] size_mask();
		logic [5:0] s;
		s = (cfg_size > MaxSizeLog2) ? MaxSizeLog2 : cfg_size;
		return (64'd1 << s) - 64'd1;
	endfunction

	function automatic void issue_cmd(input step_t st, input bit rd, input logic [63:0] off,
			input logic [63:0] data);
		logic [63:0] a;
		a = ({32'd0, cfg_base} + off) & AddrMaskWide;
		seq_step = st;
		last_read = rd;
		issued = '0;
		issued.command = rd ? CMD_READ : CMD_WRITE;
		issued.address = a[31:0];
		issued.write_data = rd ? 64'd0 : data;
	endfunction

	function automatic void finish_test(input phase_t ph, input logic [63:0] foff,
			input logic [63:0] fbits);
		seq_step = ST_IDLE;
		last_read = 1'b0;
		issued = '0;
		issued.command = (ph == PH_NONE) ? CMD_PASS : CMD_FAIL;
		issued.fail_phase = ph;
		issued.fail_offset = foff[31:0];
		issued.fail_bits = fbits;
	endfunction

	function automatic void start_device_test();
		if (cfg_full) begin
			walk_pos = 32'd0;
			issue_cmd(ST_DV_FILL, 1'b0, 64'd0, 64'd1);
		end else begin
			finish_test(PH_NONE, 64'd0, 64'd0);
		end
	endfunction

	// one completion: decide the next command from the current step
	function automatic void step_sequencer(input logic [63:0] rd);
		logic [63:0] m, w, nw, np, pat, w1;
		m = size_mask();
		w = {32'd0, walk_pos};
		nw = w << 1;
		np = {32'd0, probe_pos} << 1;
		w1 = w + 64'd1;
		case (seq_step)
			ST_DB_WR: issue_cmd(ST_DB_RD, 1'b1, 64'd0, 64'd0);
			ST_DB_RD: begin
				pat = 64'd1 << bit_pos;
				if (rd != pat) begin
					finish_test(PH_DATA_BUS, 64'd0, pat);
				end else if (bit_pos == 6'd63) begin
					if (m[0]) begin
						walk_pos = 32'd1;
						issue_cmd(ST_AB_FILL, 1'b0, 64'd1, PatA);
					end else begin
						issue_cmd(ST_AB_BASE_ANTI, 1'b0, 64'd0, Pat5);
					end
				end else begin
					bit_pos = bit_pos + 6'd1;
					issue_cmd(ST_DB_WR, 1'b0, 64'd0, 64'd1 << bit_pos);
				end
			end
			ST_AB_FILL: begin
				if ((nw & m) != 64'd0) begin
					walk_pos = nw[31:0];
					issue_cmd(ST_AB_FILL, 1'b0, nw, PatA);
				end else begin
					issue_cmd(ST_AB_BASE_ANTI, 1'b0, 64'd0, Pat5);
				end
			end
			ST_AB_BASE_ANTI: begin
				if (m[0]) begin
					walk_pos = 32'd1;
					issue_cmd(ST_AB_CHECK, 1'b1, 64'd1, 64'd0);
				end else begin
					issue_cmd(ST_AB_BASE_PAT, 1'b0, 64'd0, PatA);
				end
			end
			ST_AB_CHECK: begin
				if (rd != PatA) begin
					finish_test(PH_ADDR_STUCK, w, 64'd0);
				end else if ((nw & m) != 64'd0) begin
					walk_pos = nw[31:0];
					issue_cmd(ST_AB_CHECK, 1'b1, nw, 64'd0);
				end else begin
					issue_cmd(ST_AB_BASE_PAT, 1'b0, 64'd0, PatA);
				end
			end
			ST_AB_BASE_PAT: begin
				if (m[0]) begin
					probe_pos = 32'd1;
					issue_cmd(ST_AB_PROBE_WR, 1'b0, 64'd1, Pat5);
				end else begin
					start_device_test();
				end
			end
			ST_AB_PROBE_WR: issue_cmd(ST_AB_BASE_RD, 1'b1, 64'd0, 64'd0);
			ST_AB_BASE_RD: begin
				if (rd != PatA) begin
					finish_test(PH_BASE_DIST, {32'd0, probe_pos}, 64'd0);
				end else begin
					walk_pos = 32'd1;
					issue_cmd(ST_AB_SCAN, 1'b1, 64'd1, 64'd0);
				end
			end
			ST_AB_SCAN: begin
				// the probe offset itself holds the other pattern and is not compared
				if (rd != PatA && walk_pos != probe_pos) begin
					finish_test(PH_ALIAS, {32'd0, probe_pos}, 64'd0);
				end else if ((nw & m) != 64'd0) begin
					walk_pos = nw[31:0];
					issue_cmd(ST_AB_SCAN, 1'b1, nw, 64'd0);
				end else begin
					issue_cmd(ST_AB_RESTORE, 1'b0, {32'd0, probe_pos}, PatA);
				end
			end
			ST_AB_RESTORE: begin
				if ((np & m) != 64'd0) begin
					probe_pos = np[31:0];
					issue_cmd(ST_AB_PROBE_WR, 1'b0, np, Pat5);
				end else begin
					start_device_test();
				end
			end
			ST_DV_FILL: begin
				if (w >= m) begin
					walk_pos = 32'd0;
					issue_cmd(ST_DV_CHECK1, 1'b1, 64'd0, 64'd0);
				end else begin
					walk_pos = w1[31:0];
					issue_cmd(ST_DV_FILL, 1'b0, w1, w + 64'd2);
				end
			end
			ST_DV_CHECK1: begin
				if (rd != w1)
					finish_test(PH_PASS1, w, 64'd0);
				else
					issue_cmd(ST_DV_INVERT, 1'b0, w, ~w1);
			end
			ST_DV_INVERT: begin
				if (w >= m) begin
					walk_pos = 32'd0;
					issue_cmd(ST_DV_CHECK2, 1'b1, 64'd0, 64'd0);
				end else begin
					walk_pos = w1[31:0];
					issue_cmd(ST_DV_CHECK1, 1'b1, w1, 64'd0);
				end
			end
			ST_DV_CHECK2: begin
				if (rd != ~w1) begin
					finish_test(PH_PASS2, w, 64'd0);
				end else if (w >= m) begin
					finish_test(PH_NONE, 64'd0, 64'd0);
				end else begin
					walk_pos = w1[31:0];
					issue_cmd(ST_DV_CHECK2, 1'b1, w1, 64'd0);
				end
			end
			default: begin
				// completion while idle or finished
				seq_step = ST_IDLE;
				last_read = 1'b0;
				issued = '0;
			end
		endcase
	endfunction

	function automatic void predict_request(input logic act, input logic [63:0] rd);
		if (act == ACT_START) begin
			walk_pos = 32'd0;
			probe_pos = 32'd0;
			bit_pos = 6'd0;
			issue_cmd(ST_DB_WR, 1'b0, 64'd0, 64'd1);
		end else begin
			step_sequencer(last_read ? rd : 64'd0);
		end
		expected_cmds.push_back(issued);
		n_requests++;
		if (issued.command == CMD_WRITE)
			mem_image[issued.address] = issued.write_data;
		if (issued.command == CMD_PASS)
			n_pass++;
		if (issued.command == CMD_FAIL) begin
			n_fail++;
			phases_seen[issued.fail_phase] = 1'b1;
		end
	endfunction

	// data the memory returns for the last command, now and then with one bit flipped
	function automatic logic [63:0] memory_answer();
		logic [63:0] d;
		if (issued.command != CMD_READ)
			return rand64();
		d = mem_image.exists(issued.address) ? mem_image[issued.address] : rand64();
		if (corrupt_odds != 0 && $urandom_range(1, corrupt_odds) == 1)
			d = d ^ (64'd1 << $urandom_range(0, 63));
		return d;
	endfunction

	function automatic logic [31:0] reg_value(input reg_idx_t r);
		case (r)
			REG_BASE: return cfg_base;
			REG_SIZE: return {26'd0, cfg_size};
			REG_FULL: return {31'd0, cfg_full};
			default:  return 32'd0;
		endcase
	endfunction

	task automatic write_reg(input reg_idx_t r, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (r)
			REG_BASE: cfg_base = data;
			REG_SIZE: cfg_size = data[5:0];
			REG_FULL: cfg_full = data[0];
			default: ;
		endcase
	endtask

	task automatic read_reg(input reg_idx_t r, output logic [31:0] v);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {r, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		v = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic readback_regs();
		logic [31:0] v;
		read_reg(REG_BASE, v);
		check_field("base_word_address", {32'd0, reg_value(REG_BASE)}, {32'd0, v});
		read_reg(REG_SIZE, v);
		check_field("size_log2", {32'd0, reg_value(REG_SIZE)}, {32'd0, v});
		read_reg(REG_FULL, v);
		check_field("full_test", {32'd0, reg_value(REG_FULL)}, {32'd0, v});
	endtask

	task automatic apply_config(input logic [31:0] base, input logic [5:0] size,
			input logic full);
		logic [31:0] noise;
		noise = $urandom;
		write_reg(REG_BASE, base);
		write_reg(REG_SIZE, {noise[31:6], size});
		write_reg(REG_FULL, {noise[31:1], full});
		readback_regs();
	endtask

	task automatic send_request(input logic act, input logic [63:0] rd);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= rd;
		do @(posedge clk); while (!s_tready);
		predict_request(act, rd);
	endtask

	// hold off new requests until every expected command has come out
	task automatic wait_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_cmds.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// one self-test against the memory image, cut short after cap requests, at times with one more completion after
	task automatic run_sequence(input int cap, inout int count);
		int n, r;
		n_runs++;
		corrupt_odds = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(8, 200);
		mem_image.delete();
		send_request(ACT_START, rand64());
		n = 1;
		while (n < cap && issued.command != CMD_PASS && issued.command != CMD_FAIL) begin
			r = $urandom_range(0, 999);
			if (r < 3)
				send_request(ACT_START, rand64());
			else if (r < 8)
				send_request(ACT_DONE, rand64());
			else
				send_request(ACT_DONE, memory_answer());
			if ($urandom_range(0, 99) == 0)
				wait_results();
			n++;
		end
		if ($urandom_range(0, 1) == 0) begin
			send_request(ACT_DONE, rand64());
			n++;
		end
		count += n;
	endtask

	task automatic test_register_defaults();
		readback_regs();
	endtask

	task automatic test_idle_completion();
		send_request(ACT_DONE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(ACT_DONE, 64'd0);
		wait_results();
	endtask

	task automatic test_data_bus_fault();
		apply_config(32'hFFFF_FFFF, 6'd1, 1'b0);
		// bit 0 reads back as zero
		send_request(ACT_START, 64'd0);
		send_request(ACT_DONE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(ACT_DONE, 64'd0);
		send_request(ACT_DONE, 64'd1);
		// bit 1 reads back with every bit set
		send_request(ACT_START, 64'd0);
		send_request(ACT_DONE, 64'd0);
		send_request(ACT_DONE, 64'd1);
		send_request(ACT_DONE, 64'd0);
		send_request(ACT_DONE, 64'hFFFF_FFFF_FFFF_FFFF);
		wait_results();
		// restart in the middle of a test
		apply_config(32'd0, 6'd0, 1'b1);
		send_request(ACT_START, 64'd0);
		send_request(ACT_DONE, 64'd0);
		send_request(ACT_START, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(ACT_DONE, 64'd0);
		send_request(ACT_DONE, 64'd1);
		wait_results();
	endtask

	task automatic test_random_runs();
		int count, r;
		logic [31:0] base;
		logic [5:0] size;
		count = 0;
		while (count < 950) begin
			r = $urandom_range(0, 99);
			if (r < 20)
				base = 32'd0;
			else if (r < 40)
				base = 32'hFFFF_FFFF;
			else if (r < 55)
				base = 32'hFFFF_FFFF - $urandom_range(0, 40);
			else
				base = $urandom;
			r = $urandom_range(0, 99);
			if (r < 60)
				size = 6'($urandom_range(1, 4));
			else if (r < 72)
				size = 6'd0;
			else if (r < 88)
				size = 6'($urandom_range(5, 7));
			else
				size = 6'($urandom_range(8, 63));
			calm = ($urandom_range(0, 4) == 0);
			apply_config(base, size, 1'($urandom_range(0, 1)));
			run_sequence(300, count);
			wait_results();
		end
		calm = 1'b0;
	endtask

	task automatic test_large_sizes();
		int count;
		count = 0;
		apply_config(32'hFFFF_FFFF, 6'd32, 1'b1);
		run_sequence(200, count);
		wait_results();
		apply_config($urandom, 6'd33, 1'b0);
		run_sequence(200, count);
		wait_results();
		apply_config(32'h8000_0000, 6'd63, 1'b1);
		run_sequence(200, count);
		wait_results();
	endtask

	// result checker
	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_cmds.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, command %0d", $time, m_tuser);
			end else begin
				want = expected_cmds.pop_front();
				check_field("command", {61'd0, want.command}, {61'd0, m_tuser});
				check_field("address", {32'd0, want.address}, {32'd0, m_tdata[31:0]});
				check_field("write_data", want.write_data, m_tdata[95:32]);
				check_field("fail_phase", {61'd0, want.fail_phase}, {61'd0, m_tdata[98:96]});
				check_field("fail_offset", {32'd0, want.fail_offset}, {32'd0, m_tdata[130:99]});
				check_field("fail_bits", want.fail_bits, m_tdata[194:131]);
				check_field("fill", 64'd0, {59'd0, m_tdata[199:195]});
			end
		end
	end

	// result side: ready bursts with stalls of random length, and no stalls while calm
	initial begin
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, calm ? 200 : 12)) @(posedge clk);
			if (!calm) begin
				m_tready <= 1'b0;
				repeat (1 + pick_gap()) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= ACT_START;
		s_tdata  <= 64'd0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= 32'd0;
		errors = 0;
		calm = 1'b0;
		corrupt_odds = 0;
		n_requests = 0;
		n_runs = 0;
		n_pass = 0;
		n_fail = 0;
		phases_seen = '0;
		cfg_base = 32'd0;
		cfg_size = 6'd16;
		cfg_full = 1'b1;
		seq_step = ST_IDLE;
		walk_pos = 32'd0;
		probe_pos = 32'd0;
		bit_pos = 6'd0;
		last_read = 1'b0;
		issued = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_register_defaults();
		test_idle_completion();
		test_data_bus_fault();
		test_random_runs();
		test_large_sizes();
		wait_results();

		$display("covered %0d requests in %0d self-test runs: %0d passed, %0d failed",
			n_requests, n_runs, n_pass, n_fail);
		$display("failure phases reported (bit per phase): %b", phases_seen);
		if (errors == 0 && expected_cmds.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[filelist.f]
rtl/mbist_pkg.sv
rtl/mbist_regs.sv
rtl/mbist_seq.sv
rtl/memory_bist_sequencer.sv
tb/testbench.sv
